// File: sv/ycbcr_column_histogram_parade_assert.svh
// Assertion helpers for the parade scope; they expect clock and reset in scope.
`ifndef YCBCR_COLUMN_HISTOGRAM_PARADE_ASSERT_SVH
`define YCBCR_COLUMN_HISTOGRAM_PARADE_ASSERT_SVH

// Same-cycle implication.
`define YCHP_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ycbcr parade: implication check failed");

// Next-cycle implication.
`define YCHP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ycbcr parade: next-cycle check failed");

`endif

// File: sv/ychp_pkg.sv
`default_nettype none

package ychp_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int COUNT_BITS  = 16;
   localparam int LEVELS      = 256;

   localparam int LEVEL_BITS    = $clog2(LEVELS);
   localparam int COL_ADDR_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ADDR_BITS     = COL_ADDR_BITS + LEVEL_BITS;
   localparam int BIN_TOTAL     = MAX_COLUMNS * LEVELS;
   localparam int NUM_CHANNELS  = 3;

   localparam int COMMAND_BITS   = 2;
   localparam int CHANNEL_BITS   = 2;
   localparam int COLOUR_BITS    = 8;
   localparam int COLUMN_BITS    = 10;
   localparam int INTENSITY_BITS = 8;
   localparam int RAW_BITS       = 16;

   localparam int GAIN_BITS         = 9;
   localparam int COLUMN_COUNT_BITS = 11;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = 11;
   localparam int GAIN_RESET         = 100;
   localparam int COLUMN_COUNT_RESET = 1024;
   localparam int INTENSITY_MAX      = 255;
   localparam int PROD_BITS          = GAIN_BITS + COUNT_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ENABLED      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN         = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd2;

   // Luma scaled by 1000, chroma scaled by 31250 (10^6 / 32).
   localparam int YSUM_BITS    = 18;
   localparam int CSUM_BITS    = 23;
   localparam int Y_COEF_RED   = 299;
   localparam int Y_COEF_GREEN = 587;
   localparam int Y_COEF_BLUE  = 114;
   localparam int C_OFFSET     = 4000000;
   localparam int CB_COEF_RED   = 5273;
   localparam int CB_COEF_GREEN = 10352;
   localparam int CB_COEF_BLUE  = 15625;
   localparam int CR_COEF_RED   = 15625;
   localparam int CR_COEF_GREEN = 13084;
   localparam int CR_COEF_BLUE  = 2541;

   // Divide by 1000 and by 31250 through rounded-up reciprocals; exact over the sum ranges.
   localparam int Y_RECIP       = 134218;
   localparam int Y_RECIP_BITS  = 18;
   localparam int Y_RECIP_SHIFT = 27;
   localparam int C_RECIP       = 8796094;
   localparam int C_RECIP_BITS  = 24;
   localparam int C_RECIP_SHIFT = 38;

   typedef enum logic [COMMAND_BITS-1:0] {
      CMD_ACCUMULATE = 2'd0,
      CMD_CLEAR      = 2'd1,
      CMD_READ       = 2'd2
   } cmd_type;

   typedef enum logic [CHANNEL_BITS-1:0] {
      CH_LUMA      = 2'd0,
      CH_BLUE_DIFF = 2'd1,
      CH_RED_DIFF  = 2'd2
   } channel_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PRODUCT,
      ST_SUM,
      ST_DIVIDE,
      ST_ACC_READ,
      ST_ACC_WRITE,
      ST_RD_RESULT
   } state_type;

endpackage

`default_nettype wire

// File: sv/ychp_ram.sv
`default_nettype none

module ychp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/ycbcr_column_histogram_parade.sv
// channel  dir  handshake               payload
// req      in   req_valid / req_stall   command red green blue column channel level
// rsp      out  rsp_valid / rsp_stall   intensity raw_count
// csr      in   csr_write               csr_index csr_data
//
// Accumulate: product, sum and reciprocal-multiply stages, then bin read and
//   write-back through each memory.
// Read: the bin memory read is registered before the result is formed.
// Reset and clear: a sweep over MAX_COLUMNS * LEVELS = 262144 addresses zeroes all
//   three bin memories one address per cycle; req_stall stays high meanwhile.
// Reset is synchronous, active high. A result waits in the output register
//   under rsp_stall; a later read result holds until that register frees.
`default_nettype none
`include "ycbcr_column_histogram_parade_assert.svh"

module ycbcr_column_histogram_parade (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [ychp_pkg::COMMAND_BITS-1:0]    req_command,
   input  wire logic [ychp_pkg::COLOUR_BITS-1:0]     req_red,
   input  wire logic [ychp_pkg::COLOUR_BITS-1:0]     req_green,
   input  wire logic [ychp_pkg::COLOUR_BITS-1:0]     req_blue,
   input  wire logic [ychp_pkg::COLUMN_BITS-1:0]     req_column,
   input  wire logic [ychp_pkg::CHANNEL_BITS-1:0]    req_channel,
   input  wire logic [ychp_pkg::LEVEL_BITS-1:0]      req_level,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [ychp_pkg::INTENSITY_BITS-1:0]  rsp_intensity,
   output logic      [ychp_pkg::RAW_BITS-1:0]        rsp_raw_count,
   input  wire logic                                 csr_write,
   input  wire logic [ychp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [ychp_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int YB = ychp_pkg::YSUM_BITS;
   localparam int CB = ychp_pkg::CSUM_BITS;
   localparam int AB = ychp_pkg::ADDR_BITS;
   localparam int LB = ychp_pkg::LEVEL_BITS;
   localparam int NB = ychp_pkg::COUNT_BITS;
   localparam int YP = YB + ychp_pkg::Y_RECIP_BITS;
   localparam int CP = CB + ychp_pkg::C_RECIP_BITS;

   ychp_pkg::state_type state_ff, state_in;

   logic                                        enabled_ff;
   logic [ychp_pkg::GAIN_BITS-1:0]              gain_ff;
   logic [ychp_pkg::COLUMN_COUNT_BITS-1:0]      column_count_ff;

   logic [ychp_pkg::COLOUR_BITS-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [ychp_pkg::COL_ADDR_BITS-1:0] col_addr_ff, col_addr_in;
   logic [ychp_pkg::CHANNEL_BITS-1:0]  channel_ff, channel_in;
   logic                               read_zero_ff, read_zero_in;

   logic [YB-1:0] py_r_ff, py_r_in, py_g_ff, py_g_in, py_b_ff, py_b_in;
   logic [CB-1:0] pcb_r_ff, pcb_r_in, pcb_g_ff, pcb_g_in, pcb_b_ff, pcb_b_in;
   logic [CB-1:0] pcr_r_ff, pcr_r_in, pcr_g_ff, pcr_g_in, pcr_b_ff, pcr_b_in;

   logic [YB-1:0] rem_y_ff, rem_y_in;
   logic [CB-1:0] rem_cb_ff, rem_cb_in, rem_cr_ff, rem_cr_in;
   logic [LB-1:0] q_y_ff, q_y_in, q_cb_ff, q_cb_in, q_cr_ff, q_cr_in;
   logic [AB-1:0] clear_addr_ff, clear_addr_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ychp_pkg::INTENSITY_BITS-1:0] rsp_intensity_ff, rsp_intensity_in;
   logic [ychp_pkg::RAW_BITS-1:0]       rsp_raw_count_ff, rsp_raw_count_in;

   logic          ram_we;
   logic          ram_re;
   logic [AB-1:0] ram_wr_addr [ychp_pkg::NUM_CHANNELS];
   logic [AB-1:0] ram_rd_addr [ychp_pkg::NUM_CHANNELS];
   logic [NB-1:0] ram_wr_data [ychp_pkg::NUM_CHANNELS];
   logic [NB-1:0] ram_rd_data [ychp_pkg::NUM_CHANNELS];

   logic accept;
   logic col_in_use;
   logic out_free;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ychp_pkg::ST_IDLE);
   assign col_in_use = ({1'b0, req_column} < column_count_ff)
                       && (int'(req_column) < ychp_pkg::MAX_COLUMNS);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_intensity_ff;
   assign rsp_raw_count = rsp_raw_count_ff;

   always_comb begin
      logic [YP-1:0] y_prod;
      logic [CP-1:0] cb_prod;
      logic [CP-1:0] cr_prod;
      logic [AB-1:0] req_addr;
      logic [NB-1:0] cnt;
      logic [ychp_pkg::PROD_BITS-1:0] prod;

      state_in         = state_ff;
      red_in           = red_ff;
      green_in         = green_ff;
      blue_in          = blue_ff;
      col_addr_in      = col_addr_ff;
      channel_in       = channel_ff;
      read_zero_in     = read_zero_ff;
      py_r_in          = py_r_ff;
      py_g_in          = py_g_ff;
      py_b_in          = py_b_ff;
      pcb_r_in         = pcb_r_ff;
      pcb_g_in         = pcb_g_ff;
      pcb_b_in         = pcb_b_ff;
      pcr_r_in         = pcr_r_ff;
      pcr_g_in         = pcr_g_ff;
      pcr_b_in         = pcr_b_ff;
      rem_y_in         = rem_y_ff;
      rem_cb_in        = rem_cb_ff;
      rem_cr_in        = rem_cr_ff;
      q_y_in           = q_y_ff;
      q_cb_in          = q_cb_ff;
      q_cr_in          = q_cr_ff;
      clear_addr_in    = clear_addr_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_intensity_in = rsp_intensity_ff;
      rsp_raw_count_in = rsp_raw_count_ff;

      y_prod   = YP'(rem_y_ff) * YP'(ychp_pkg::Y_RECIP);
      cb_prod  = CP'(rem_cb_ff) * CP'(ychp_pkg::C_RECIP);
      cr_prod  = CP'(rem_cr_ff) * CP'(ychp_pkg::C_RECIP);
      req_addr = {ychp_pkg::COL_ADDR_BITS'(req_column), req_level};
      cnt      = '0;
      prod     = '0;

      ram_we = 1'b0;
      ram_re = 1'b0;
      for (int i = 0; i < ychp_pkg::NUM_CHANNELS; i++) begin
         ram_rd_addr[i] = req_addr;
         ram_wr_addr[i] = clear_addr_ff;
         ram_wr_data[i] = (ram_rd_data[i] == '1) ? ram_rd_data[i]
                                                 : ram_rd_data[i] + NB'(1);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ychp_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            for (int i = 0; i < ychp_pkg::NUM_CHANNELS; i++) begin
               ram_wr_data[i] = '0;
            end
            clear_addr_in = clear_addr_ff + AB'(1);
            if (clear_addr_ff == AB'(ychp_pkg::BIN_TOTAL - 1)) begin
               state_in = ychp_pkg::ST_IDLE;
            end
         end
         ychp_pkg::ST_IDLE: begin
            if (accept && enabled_ff) begin
               case (ychp_pkg::cmd_type'(req_command))
                  ychp_pkg::CMD_ACCUMULATE: begin
                     if (col_in_use) begin
                        red_in      = req_red;
                        green_in    = req_green;
                        blue_in     = req_blue;
                        col_addr_in = ychp_pkg::COL_ADDR_BITS'(req_column);
                        state_in    = ychp_pkg::ST_PRODUCT;
                     end
                  end
                  ychp_pkg::CMD_CLEAR: begin
                     clear_addr_in = '0;
                     state_in      = ychp_pkg::ST_CLEAR;
                  end
                  ychp_pkg::CMD_READ: begin
                     ram_re       = 1'b1;
                     channel_in   = req_channel;
                     read_zero_in = !col_in_use;
                     state_in     = ychp_pkg::ST_RD_RESULT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ychp_pkg::ST_PRODUCT: begin
            py_r_in  = YB'(ychp_pkg::Y_COEF_RED) * YB'(red_ff);
            py_g_in  = YB'(ychp_pkg::Y_COEF_GREEN) * YB'(green_ff);
            py_b_in  = YB'(ychp_pkg::Y_COEF_BLUE) * YB'(blue_ff);
            pcb_r_in = CB'(ychp_pkg::CB_COEF_RED) * CB'(red_ff);
            pcb_g_in = CB'(ychp_pkg::CB_COEF_GREEN) * CB'(green_ff);
            pcb_b_in = CB'(ychp_pkg::CB_COEF_BLUE) * CB'(blue_ff);
            pcr_r_in = CB'(ychp_pkg::CR_COEF_RED) * CB'(red_ff);
            pcr_g_in = CB'(ychp_pkg::CR_COEF_GREEN) * CB'(green_ff);
            pcr_b_in = CB'(ychp_pkg::CR_COEF_BLUE) * CB'(blue_ff);
            state_in = ychp_pkg::ST_SUM;
         end
         ychp_pkg::ST_SUM: begin
            rem_y_in    = py_r_ff + py_g_ff + py_b_ff;
            rem_cb_in   = CB'(ychp_pkg::C_OFFSET) + pcb_b_ff - pcb_r_ff - pcb_g_ff;
            rem_cr_in   = CB'(ychp_pkg::C_OFFSET) + pcr_r_ff - pcr_g_ff - pcr_b_ff;
            q_y_in      = '0;
            q_cb_in     = '0;
            q_cr_in     = '0;
            state_in    = ychp_pkg::ST_DIVIDE;
         end
         ychp_pkg::ST_DIVIDE: begin
            q_y_in   = y_prod[ychp_pkg::Y_RECIP_SHIFT +: LB];
            q_cb_in  = cb_prod[ychp_pkg::C_RECIP_SHIFT +: LB];
            q_cr_in  = cr_prod[ychp_pkg::C_RECIP_SHIFT +: LB];
            state_in = ychp_pkg::ST_ACC_READ;
         end
         ychp_pkg::ST_ACC_READ: begin
            ram_re         = 1'b1;
            ram_rd_addr[0] = {col_addr_ff, q_y_ff};
            ram_rd_addr[1] = {col_addr_ff, q_cb_ff};
            ram_rd_addr[2] = {col_addr_ff, q_cr_ff};
            state_in       = ychp_pkg::ST_ACC_WRITE;
         end
         ychp_pkg::ST_ACC_WRITE: begin
            ram_we         = 1'b1;
            ram_wr_addr[0] = {col_addr_ff, q_y_ff};
            ram_wr_addr[1] = {col_addr_ff, q_cb_ff};
            ram_wr_addr[2] = {col_addr_ff, q_cr_ff};
            state_in       = ychp_pkg::ST_IDLE;
         end
         ychp_pkg::ST_RD_RESULT: begin
            case (ychp_pkg::channel_type'(channel_ff))
               ychp_pkg::CH_LUMA:      cnt = ram_rd_data[0];
               ychp_pkg::CH_BLUE_DIFF: cnt = ram_rd_data[1];
               ychp_pkg::CH_RED_DIFF:  cnt = ram_rd_data[2];
               default:                cnt = '0;
            endcase
            if (read_zero_ff) begin
               cnt = '0;
            end
            prod = ychp_pkg::PROD_BITS'(gain_ff) * ychp_pkg::PROD_BITS'(cnt);
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_raw_count_in = ychp_pkg::RAW_BITS'(cnt);
               rsp_intensity_in = (prod > ychp_pkg::PROD_BITS'(ychp_pkg::INTENSITY_MAX))
                                  ? ychp_pkg::INTENSITY_BITS'(ychp_pkg::INTENSITY_MAX)
                                  : prod[ychp_pkg::INTENSITY_BITS-1:0];
               state_in         = ychp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ychp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ychp_pkg::ST_CLEAR;
         clear_addr_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         enabled_ff      <= 1'b0;
         gain_ff         <= ychp_pkg::GAIN_BITS'(ychp_pkg::GAIN_RESET);
         column_count_ff <= ychp_pkg::COLUMN_COUNT_BITS'(ychp_pkg::COLUMN_COUNT_RESET);
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               ychp_pkg::REG_ENABLED:      enabled_ff      <= csr_data[0];
               ychp_pkg::REG_GAIN:         gain_ff         <= csr_data[ychp_pkg::GAIN_BITS-1:0];
               ychp_pkg::REG_COLUMN_COUNT: column_count_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      red_ff           <= red_in;
      green_ff         <= green_in;
      blue_ff          <= blue_in;
      col_addr_ff      <= col_addr_in;
      channel_ff       <= channel_in;
      read_zero_ff     <= read_zero_in;
      py_r_ff          <= py_r_in;
      py_g_ff          <= py_g_in;
      py_b_ff          <= py_b_in;
      pcb_r_ff         <= pcb_r_in;
      pcb_g_ff         <= pcb_g_in;
      pcb_b_ff         <= pcb_b_in;
      pcr_r_ff         <= pcr_r_in;
      pcr_g_ff         <= pcr_g_in;
      pcr_b_ff         <= pcr_b_in;
      rem_y_ff         <= rem_y_in;
      rem_cb_ff        <= rem_cb_in;
      rem_cr_ff        <= rem_cr_in;
      q_y_ff           <= q_y_in;
      q_cb_ff          <= q_cb_in;
      q_cr_ff          <= q_cr_in;
      rsp_intensity_ff <= rsp_intensity_in;
      rsp_raw_count_ff <= rsp_raw_count_in;
   end

   for (genvar g = 0; g < ychp_pkg::NUM_CHANNELS; g++) begin : g_bins
      ychp_ram #(
         .WIDTH (NB),
         .DEPTH (ychp_pkg::BIN_TOTAL)
      ) u_bins (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (ram_wr_addr[g]),
         .wr_data (ram_wr_data[g]),
         .rd_en   (ram_re),
         .rd_addr (ram_rd_addr[g]),
         .rd_data (ram_rd_data[g])
      );
   end

   `YCHP_ASSERT_IMPLIES(a_result_from_read, $rose(rsp_valid_ff),
                        $past(state_ff) == ychp_pkg::ST_RD_RESULT)
   `YCHP_ASSERT_NEXT(a_sweep_ends_idle,
                     state_ff == ychp_pkg::ST_CLEAR
                        && clear_addr_ff == AB'(ychp_pkg::BIN_TOTAL - 1),
                     state_ff == ychp_pkg::ST_IDLE)
   `YCHP_ASSERT_NEXT(a_divide_after_sum, state_ff == ychp_pkg::ST_SUM,
                     state_ff == ychp_pkg::ST_DIVIDE)
   `YCHP_ASSERT_IMPLIES(a_bump_after_read, state_ff == ychp_pkg::ST_ACC_WRITE,
                        $past(state_ff) == ychp_pkg::ST_ACC_READ)

endmodule

`default_nettype wire
